### rtl/overwriting_log_ring_buffer_top_assert.svh
// Assertion macros for the log ring buffer checker.
// Both expect clk and arst_n in the scope of use.
`ifndef OVERWRITING_LOG_RING_BUFFER_TOP_ASSERT_SVH
`define OVERWRITING_LOG_RING_BUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define OLRB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OLRB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/olrb_pkg.sv
`default_nettype none

package olrb_pkg;

	localparam int unsigned RING_BYTES_DEF = 16384;
	localparam int unsigned BURST_MAX_DEF  = 64;

	localparam int unsigned OFFSET_W = 32;
	localparam int unsigned COUNT_W  = 15;
	localparam int unsigned MAX_W    = 7;

	typedef enum logic {
		FUNC_APPEND = 1'b0,
		FUNC_READ   = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_NONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_PLAN,
		ST_BURST
	} state_t;

	typedef struct packed {
		func_t               func;
		logic [7:0]          log_byte;
		logic                end_of_message;
		logic [OFFSET_W-1:0] read_offset;
		logic [MAX_W-1:0]    read_max;
	} req_item_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          out_byte;
		logic [OFFSET_W-1:0] out_offset;
		logic [COUNT_W-1:0]  written_count;
		logic                last_of_burst;
	} rsp_item_t;

endpackage

`default_nettype wire

### rtl/olrb_store.sv
`default_nettype none

module olrb_store #(
	parameter int unsigned DEPTH  = 16384,
	parameter int unsigned ADDR_W = 14
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output      logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds while rd_en is low
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/overwriting_log_ring_buffer_top.sv
`default_nettype none

// Byte log ring buffer with overwrite. Appends are taken one beat per cycle while the
// response side is not stalled, and write the byte at its running 32-bit offset modulo
// RING_BYTES; a beat marked end of message returns one acknowledge beat with the capped
// message length. A read beat first passes through setup states that clamp the offset to
// the oldest kept byte, then size the burst, and then streams up to min(read_max, BURST_MAX)
// data beats, fewer if fewer bytes were written past the offset, at one per cycle while
// the response side is not stalled, or a single "nothing" beat. The byte rate is set by
// the single read port of the store and its registered read data. Appends are stalled
// while a read is in flight, so store reads and writes never meet on one entry. Store
// contents are undefined after reset; only written entries are read.
module overwriting_log_ring_buffer_top
	import olrb_pkg::*;
#(
	parameter int unsigned RING_BYTES = RING_BYTES_DEF,
	parameter int unsigned BURST_MAX  = BURST_MAX_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output      logic      req_stall,
	input  wire req_item_t req,
	output      logic      rsp_valid,
	input  wire logic      rsp_stall,
	output      rsp_item_t rsp
);

	localparam int unsigned IDX_W  = $clog2(RING_BYTES);
	localparam int unsigned LEN_W  = $clog2(RING_BYTES + 1);
	localparam int unsigned MAXC_W = $clog2(BURST_MAX + 1);

	localparam logic [IDX_W-1:0]    IDX_LAST = IDX_W'(RING_BYTES - 1);
	localparam logic [LEN_W-1:0]    RING_L   = LEN_W'(RING_BYTES);
	localparam logic [OFFSET_W-1:0] RING_O   = OFFSET_W'(RING_BYTES);
	localparam logic [MAX_W-1:0]    BURST_I  = MAX_W'(BURST_MAX);

	state_t              state_q, state_d;
	logic [OFFSET_W-1:0] tw_q;
	logic [IDX_W-1:0]    wr_idx_q;
	logic [LEN_W-1:0]    msg_len_q;
	logic [OFFSET_W-1:0] off_q;
	logic [MAXC_W-1:0]   max_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [OFFSET_W-1:0] g_q;
	logic [MAXC_W-1:0]   rem_q;
	logic                pend_s1;
	logic [OFFSET_W-1:0] g_s1;
	logic                last_s1;
	logic                rsp_valid_q;
	rsp_item_t           rsp_q;

	logic                req_acc, rsp_free;
	logic                is_append, is_read;
	logic [LEN_W-1:0]    msg_next;
	logic [IDX_W-1:0]    wr_idx_next;
	logic [MAXC_W-1:0]   max_sat;
	logic [OFFSET_W-1:0] earliest;
	logic                plan_empty;
	logic [OFFSET_W-1:0] dist32;
	logic [LEN_W-1:0]    span_l, wr_l;
	logic [MAXC_W-1:0]   avail;
	logic [IDX_W-1:0]    rd_start;
	logic                issue, burst_done;
	logic                load_ack, load_none, load_data;
	rsp_item_t           rsp_d;
	logic [7:0]          rd_data;

	olrb_store #(
		.DEPTH  (RING_BYTES),
		.ADDR_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (req_acc && is_append),
		.wr_addr (wr_idx_q),
		.wr_data (req.log_byte),
		.rd_en   (issue),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// datapath helpers
	always_comb begin
		is_append   = (req.func == FUNC_APPEND);
		is_read     = (req.func == FUNC_READ);
		rsp_free    = !rsp_valid_q || !rsp_stall;
		msg_next    = (msg_len_q < RING_L) ? msg_len_q + 1'b1 : msg_len_q;
		// offset counter wrap restarts the entry index too
		wr_idx_next = (tw_q == '1 || wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
		max_sat     = (req.read_max > BURST_I) ? MAXC_W'(BURST_MAX) : MAXC_W'(req.read_max);
		earliest    = (tw_q > RING_O) ? tw_q - RING_O : '0;
		plan_empty  = (off_q >= tw_q) || (max_q == '0);
		dist32      = tw_q - off_q;
		span_l      = dist32[LEN_W-1:0];
		wr_l        = LEN_W'(wr_idx_q);
		avail       = (dist32 < OFFSET_W'(max_q)) ? MAXC_W'(dist32) : max_q;
		rd_start    = (wr_l >= span_l) ? IDX_W'(wr_l - span_l)
			: IDX_W'(wr_l + (RING_L - span_l));
		burst_done  = (rem_q == '0) && (!pend_s1 || rsp_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc && is_read) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				state_d = ST_PLAN;
			end
			ST_PLAN: begin
				if (!plan_empty) begin
					state_d = ST_BURST;
				end else if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BURST: begin
				if (burst_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE) || !rsp_free;
		req_acc   = req_valid && !req_stall;
		issue     = (state_q == ST_BURST) && (rem_q != '0) && (!pend_s1 || rsp_free);
		load_ack  = req_acc && is_append && req.end_of_message;
		load_none = (state_q == ST_PLAN) && plan_empty && rsp_free;
		load_data = pend_s1 && rsp_free;

		rsp_d = rsp_q;
		if (load_ack) begin
			rsp_d.kind          = KIND_ACK;
			rsp_d.out_byte      = '0;
			rsp_d.out_offset    = tw_q;
			rsp_d.written_count = COUNT_W'(msg_next);
			rsp_d.last_of_burst = 1'b1;
		end else if (load_none) begin
			rsp_d.kind          = KIND_NONE;
			rsp_d.out_byte      = '0;
			rsp_d.out_offset    = off_q;
			rsp_d.written_count = '0;
			rsp_d.last_of_burst = 1'b1;
		end else if (load_data) begin
			rsp_d.kind          = KIND_DATA;
			rsp_d.out_byte      = rd_data;
			rsp_d.out_offset    = g_s1;
			rsp_d.written_count = '0;
			rsp_d.last_of_burst = last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tw_q        <= '0;
			wr_idx_q    <= '0;
			msg_len_q   <= '0;
			rem_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_acc && is_append) begin
				tw_q      <= tw_q + 1'b1;
				wr_idx_q  <= wr_idx_next;
				msg_len_q <= req.end_of_message ? '0 : msg_next;
			end
			if (state_q == ST_PLAN) begin
				rem_q <= plan_empty ? '0 : avail;
			end else if (issue) begin
				rem_q <= rem_q - 1'b1;
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (rsp_free) begin
				pend_s1 <= 1'b0;
			end
			if (load_ack || load_none || load_data) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && is_read) begin
			off_q <= req.read_offset;
			max_q <= max_sat;
		end else if (state_q == ST_CLAMP && off_q < earliest) begin
			off_q <= earliest;
		end
		if (state_q == ST_PLAN) begin
			rd_idx_q <= rd_start;
			g_q      <= off_q;
		end else if (issue) begin
			rd_idx_q <= (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
			g_q      <= g_q + 1'b1;
		end
		if (issue) begin
			g_s1    <= g_q;
			last_s1 <= (rem_q == MAXC_W'(1));
		end
		rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### rtl/olrb_checker.sv
`default_nettype none

`include "overwriting_log_ring_buffer_top_assert.svh"

module olrb_checker
	import olrb_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_stall,
	input wire req_item_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_stall,
	input wire rsp_item_t rsp
);

	logic mid_burst;

	assign mid_burst = rsp_valid && (rsp.kind == KIND_DATA) && !rsp.last_of_burst;

	`OLRB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp beat changed while stalled")

	// a taken non-final data beat is followed at once by the next byte
	`OLRB_ASSERT_NEXT(a_burst_stream, mid_burst && !rsp_stall, rsp_valid && rsp.kind == KIND_DATA && rsp.out_offset == $past(rsp.out_offset) + 32'd1, "read burst broke its byte sequence")

	`OLRB_ASSERT_NOW(a_burst_blocks_req, mid_burst, req_stall, "request taken during a read burst")

	`OLRB_ASSERT_NOW(a_ack_shape, rsp_valid && rsp.kind == KIND_ACK, rsp.last_of_burst && rsp.out_byte == 8'd0, "malformed write acknowledge")

endmodule

bind overwriting_log_ring_buffer_top olrb_checker u_olrb_checker (.*);

`default_nettype wire
